// ===== rtl/pott_pkg.sv =====
package pott_pkg;

  // Default table depth
  localparam int TIMER_SLOTS_DEFAULT = 16;

  // Command codes on the request
  typedef enum logic [1:0] {
    FUNC_ADD       = 2'd0,
    FUNC_RM_ID     = 2'd1,
    FUNC_RM_CLIENT = 2'd2,
    FUNC_TICK      = 2'd3
  } func_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_FIRE = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  // Phase of a used slot; slots at or above the fill count are free
  typedef enum logic [1:0] {
    PH_PENDING = 2'd1,
    PH_LIVE    = 2'd2,
    PH_CANCEL  = 2'd3
  } phase_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] client_handle;
    logic [31:0] interval_ms;
    logic        single_shot;
    logic [31:0] target_id;
    logic [31:0] now_ms;
  } request_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] timer_id;
    logic [15:0] fired_client;
    logic        status;
    logic        last;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] id;
    logic [15:0] client;
    logic [31:0] interval;
    logic [31:0] last_fire;
    logic        single;
  } entry_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_DECIDE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;      // capture request, clear walk counters
    logic add;        // append entry, emit acknowledge
    logic walk;       // run the table walk
    logic scan;       // walk is read-only search
    logic mark;       // write cancel to the found entry
    logic rewind;     // restart walk counters
    logic finish;     // commit new fill count
    logic done_emit;  // emit dispatch finished
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_t func;
    logic  walk_done;
    logic  found;
  } ctrl_stat_t;

endpackage

// ===== rtl/pott_ctrl.sv =====
module pott_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  pott_pkg::func_t       start_func,
  input  pott_pkg::ctrl_stat_t  stat,
  output pott_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);
  import pott_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (start_func)
            FUNC_ADD:       state_next = ST_ADD;
            FUNC_RM_ID:     state_next = ST_SCAN;
            FUNC_RM_CLIENT: state_next = ST_WALK;
            FUNC_TICK:      state_next = ST_WALK;
          endcase
        end
      end
      ST_ADD:    state_next = ST_IDLE;
      ST_SCAN: begin
        if (stat.walk_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: state_next = stat.found ? ST_IDLE : ST_WALK;
      ST_WALK: begin
        if (stat.walk_done) state_next = (stat.func == FUNC_TICK) ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:   cmd.latch = start;
      ST_ADD:    cmd.add = 1'b1;
      ST_SCAN: begin
        cmd.walk = 1'b1;
        cmd.scan = 1'b1;
      end
      ST_DECIDE: begin
        cmd.mark   = stat.found;
        cmd.rewind = !stat.found;
      end
      ST_WALK: begin
        cmd.walk   = 1'b1;
        cmd.finish = stat.walk_done;
      end
      ST_FINISH: cmd.done_emit = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

// ===== rtl/pott_dpath.sv =====
module pott_dpath #(
  parameter int TIMER_SLOTS = pott_pkg::TIMER_SLOTS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pott_pkg::request_t    request,
  input  pott_pkg::ctrl_cmd_t   cmd,
  output pott_pkg::ctrl_stat_t  stat,
  output logic                  result_valid,
  output pott_pkg::result_t     result
);
  import pott_pkg::*;

  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TIMER_SLOTS);

  // Entry store, used slots packed from zero in order of addition
  entry_t mem [TIMER_SLOTS];

  request_t         op;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] r;
  logic [CNT_W-1:0] w;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_ent;
  logic [31:0]      next_id;
  logic             found;
  entry_t           found_ent;
  logic [IDX_W-1:0] found_idx;
  logic             dropped;

  logic             issue;
  logic             proc;
  logic             full;
  logic             keep;
  logic             fire;
  logic             drop_hit;
  logic             find_hit;
  logic [31:0]      due;
  entry_t           new_ent;
  entry_t           add_ent;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  assign issue = cmd.walk && (r < n);
  assign proc  = cmd.walk && rd_vld;
  assign full  = (n >= SLOTS_C);
  assign due   = rd_ent.last_fire + rd_ent.interval;

  // Per-entry decision on the walk
  always_comb begin
    keep     = 1'b1;
    fire     = 1'b0;
    drop_hit = 1'b0;
    new_ent  = rd_ent;
    find_hit = ((rd_ent.phase == PH_LIVE) || (rd_ent.phase == PH_CANCEL)) &&
               (rd_ent.id == op.target_id);
    unique case (op.func)
      FUNC_RM_ID: begin
        if ((rd_ent.phase == PH_PENDING) && (rd_ent.id == op.target_id) && !dropped) begin
          keep     = 1'b0;
          drop_hit = 1'b1;
        end
      end
      FUNC_RM_CLIENT: begin
        if (rd_ent.client == op.client_handle) begin
          if (rd_ent.phase == PH_LIVE) new_ent.phase = PH_CANCEL;
          if (rd_ent.phase == PH_PENDING) keep = 1'b0;
        end
      end
      FUNC_TICK: begin
        if (rd_ent.phase == PH_CANCEL) begin
          keep = 1'b0;
        end else begin
          new_ent.phase = PH_LIVE;
          if (op.now_ms >= due) begin
            fire              = 1'b1;
            new_ent.last_fire = op.now_ms;
            if (rd_ent.single) keep = 1'b0;
          end
        end
      end
      FUNC_ADD: keep = 1'b1;
    endcase
  end

  // New entry for add
  always_comb begin
    add_ent.phase     = PH_PENDING;
    add_ent.id        = next_id + 32'd1;
    add_ent.client    = op.client_handle;
    add_ent.interval  = op.interval_ms;
    add_ent.last_fire = op.now_ms;
    add_ent.single    = op.single_shot;
  end

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = w[IDX_W-1:0];
    wdata = new_ent;
    if (cmd.add && !full) begin
      we    = 1'b1;
      waddr = n[IDX_W-1:0];
      wdata = add_ent;
    end else if (cmd.mark) begin
      we          = 1'b1;
      waddr       = found_idx;
      wdata       = found_ent;
      wdata.phase = PH_CANCEL;
    end else if (proc && !cmd.scan && keep) begin
      we = 1'b1;
    end
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (issue) begin
      rd_ent <= mem[r[IDX_W-1:0]];
      rd_idx <= r[IDX_W-1:0];
    end
  end

  // Walk counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      n       <= '0;
      r       <= '0;
      w       <= '0;
      rd_vld  <= 1'b0;
      next_id <= '0;
      found   <= 1'b0;
      dropped <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.latch || cmd.rewind) begin
        r <= '0;
        w <= '0;
      end else begin
        if (issue) r <= r + 1'b1;
        if (proc && !cmd.scan && keep) w <= w + 1'b1;
      end
      if (cmd.latch) begin
        found   <= 1'b0;
        dropped <= 1'b0;
      end else begin
        if (proc && cmd.scan && find_hit && !found) found <= 1'b1;
        if (proc && !cmd.scan && drop_hit) dropped <= 1'b1;
      end
      if (cmd.add && !full) begin
        n       <= n + 1'b1;
        next_id <= next_id + 32'd1;
      end else if (cmd.finish) begin
        n <= w;
      end
    end
  end

  // Captured request and found entry
  always_ff @(posedge clk) begin
    if (cmd.latch) op <= request;
    if (proc && cmd.scan && find_hit && !found) begin
      found_ent <= rd_ent;
      found_idx <= rd_idx;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.add || (proc && !cmd.scan && fire) || cmd.done_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      result.kind         <= KIND_ACK;
      result.timer_id     <= full ? 32'd0 : next_id + 32'd1;
      result.fired_client <= '0;
      result.status       <= full;
      result.last         <= 1'b1;
    end else if (cmd.done_emit) begin
      result.kind         <= KIND_DONE;
      result.timer_id     <= '0;
      result.fired_client <= '0;
      result.status       <= 1'b0;
      result.last         <= 1'b1;
    end else if (proc && fire) begin
      result.kind         <= KIND_FIRE;
      result.timer_id     <= rd_ent.id;
      result.fired_client <= rd_ent.client;
      result.status       <= 1'b0;
      result.last         <= 1'b0;
    end
  end

  assign stat.func      = op.func;
  assign stat.walk_done = !rd_vld && (r == n);
  assign stat.found     = found;

endmodule

// ===== rtl/periodic_oneshot_timer_table_core.sv =====
// Timer table of TIMER_SLOTS entries kept in order of addition. A request is
// taken when start is high and busy is low; results come out one per cycle on
// result, each marked by result_valid for one cycle, and cannot be held off,
// so the receiver must take every beat. An add keeps busy high while it
// writes the entry and returns its acknowledge in the cycle after that.
// Remove by client walks the table once. Remove by id first searches the
// table and, when it finds a live or cancelled entry of that id, cancels it;
// otherwise it walks the table a second time to free a pending one. A tick
// walks the table once, with its fire beats during the walk and the
// dispatch-finished beat in the first cycle after busy falls. Each walk
// goes over the entry memory, which reads one entry and writes one entry a
// cycle (the search of a remove by id only reads), drains its registered
// read before it ends, and closes the gaps left by freed entries as it goes.
module periodic_oneshot_timer_table_core #(
  parameter int TIMER_SLOTS = pott_pkg::TIMER_SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pott_pkg::request_t request,
  output logic               result_valid,
  output pott_pkg::result_t  result
);
  import pott_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  pott_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_func (request.func),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  pott_dpath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
